// File: sv/ptoc_pkg.sv
`default_nettype none

package ptoc_pkg;

  localparam int unsigned MAX_SIDE     = 4096;
  localparam int unsigned MAX_CHANNELS = 4;

  localparam int unsigned SIDE_W     = 13;
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned CNT_W      = 3;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned THR_W      = 17;
  localparam int unsigned SUM_W      = 10;
  localparam int unsigned DIFF_W     = SIDE_W + 1;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned PROD_W     = 27;
  localparam int unsigned NUM_W      = 34;
  localparam int unsigned INDEX_W    = 24;
  localparam int unsigned VALUE_W    = 8;
  localparam int unsigned DIV_BITS   = 7;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned LATENCY    = 12;

  localparam int unsigned DIV3_W     = 20;
  localparam int unsigned DIV3_SHIFT = 11;
  localparam logic [DIV3_W-1:0] DIV3_MUL = 20'd683;
  localparam logic [NUM_W-1:0]  NUM_MUL  = 34'd98;

  localparam logic [MODE_W-1:0] MODE_TRINARY = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SCALED  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RAW     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_PRESENT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_COLORS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_MODE      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OCC_THRESHOLD = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FREE_THRESHOLD = 3'd7;

  localparam logic [THR_W-1:0] OCC_THR_RESET  = 17'd42598;
  localparam logic [THR_W-1:0] FREE_THR_RESET = 17'd12452;

  localparam logic [VALUE_W-1:0] VAL_FREE       = 8'd0;
  localparam logic [VALUE_W-1:0] VAL_SCALED_MIN = 8'd1;
  localparam logic [VALUE_W-1:0] VAL_OCCUPIED   = 8'd100;
  localparam logic [VALUE_W-1:0] VAL_UNKNOWN    = 8'd255;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_column;
    logic [COORD_W-1:0] pixel_row;
    logic [CHAN_W-1:0]  chan_zero;
    logic [CHAN_W-1:0]  chan_one;
    logic [CHAN_W-1:0]  chan_two;
    logic [CHAN_W-1:0]  chan_three;
  } pix_t;

  typedef struct packed {
    logic [INDEX_W-1:0] cell_index;
    logic [VALUE_W-1:0] cell_value;
  } cell_t;

  typedef struct packed {
    logic [SIDE_W-1:0] width;
    logic [SIDE_W-1:0] height;
    logic [CNT_W-1:0]  chans;
    logic              alpha;
    logic              invert;
    logic [MODE_W-1:0] mode;
    logic [THR_W-1:0]  occ_thr;
    logic [THR_W-1:0]  free_thr;
  } cfg_t;

  typedef struct packed {
    logic [INDEX_W-1:0] index_prod;
    logic [COORD_W-1:0] col;
    logic [PROD_W-1:0]  d;
    logic [PROD_W-1:0]  occ_lim;
    logic [PROD_W-1:0]  free_lim;
    logic [VALUE_W-1:0] raw_value;
    logic               alpha_zero;
  } prep_t;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] value_fix;
    logic               need_div;
  } side_t;

  typedef struct packed {
    side_t             side;
    logic [NUM_W-1:0]  num;
    logic [PROD_W-1:0] den;
  } div_in_t;

  typedef struct packed {
    side_t               side;
    logic [DIV_BITS-1:0] quo;
  } div_out_t;

endpackage

`default_nettype wire

// File: sv/ptoc_cfg_regs.sv
`default_nettype none

module ptoc_cfg_regs (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [ptoc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [ptoc_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output ptoc_pkg::cfg_t                        cfg_o
);

  ptoc_pkg::cfg_t cfg_q;
  logic [ptoc_pkg::SIDE_W-1:0] side_raw;
  logic [ptoc_pkg::SIDE_W-1:0] side_clamped;
  logic [ptoc_pkg::CNT_W-1:0]  cnt_raw;
  logic [ptoc_pkg::CNT_W-1:0]  cnt_clamped;

  // Sizes and the channel count are saturated into their legal ranges on write.
  always_comb begin
    side_raw = cfg_wdata_i[ptoc_pkg::SIDE_W-1:0];
    cnt_raw  = cfg_wdata_i[ptoc_pkg::CNT_W-1:0];
    if (side_raw == '0) begin
      side_clamped = ptoc_pkg::SIDE_W'(1);
    end else if (side_raw > ptoc_pkg::SIDE_W'(ptoc_pkg::MAX_SIDE)) begin
      side_clamped = ptoc_pkg::SIDE_W'(ptoc_pkg::MAX_SIDE);
    end else begin
      side_clamped = side_raw;
    end
    if (cnt_raw == '0) begin
      cnt_clamped = ptoc_pkg::CNT_W'(1);
    end else if (cnt_raw > ptoc_pkg::CNT_W'(ptoc_pkg::MAX_CHANNELS)) begin
      cnt_clamped = ptoc_pkg::CNT_W'(ptoc_pkg::MAX_CHANNELS);
    end else begin
      cnt_clamped = cnt_raw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width    <= ptoc_pkg::SIDE_W'(1);
      cfg_q.height   <= ptoc_pkg::SIDE_W'(1);
      cfg_q.chans    <= ptoc_pkg::CNT_W'(1);
      cfg_q.alpha    <= 1'b0;
      cfg_q.invert   <= 1'b0;
      cfg_q.mode     <= ptoc_pkg::MODE_TRINARY;
      cfg_q.occ_thr  <= ptoc_pkg::OCC_THR_RESET;
      cfg_q.free_thr <= ptoc_pkg::FREE_THR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ptoc_pkg::REG_MAP_WIDTH:      cfg_q.width    <= side_clamped;
        ptoc_pkg::REG_MAP_HEIGHT:     cfg_q.height   <= side_clamped;
        ptoc_pkg::REG_CHANNEL_COUNT:  cfg_q.chans    <= cnt_clamped;
        ptoc_pkg::REG_ALPHA_PRESENT:  cfg_q.alpha    <= cfg_wdata_i[0];
        ptoc_pkg::REG_INVERT_COLORS:  cfg_q.invert   <= cfg_wdata_i[0];
        ptoc_pkg::REG_MAP_MODE:       cfg_q.mode     <= cfg_wdata_i[ptoc_pkg::MODE_W-1:0];
        ptoc_pkg::REG_OCC_THRESHOLD:  cfg_q.occ_thr  <= cfg_wdata_i[ptoc_pkg::THR_W-1:0];
        ptoc_pkg::REG_FREE_THRESHOLD: cfg_q.free_thr <= cfg_wdata_i[ptoc_pkg::THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: sv/ptoc_prep.sv
`default_nettype none

module ptoc_prep (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire ptoc_pkg::pix_t  pix_i,
  input  wire ptoc_pkg::cfg_t  cfg_i,
  output logic                 valid_o,
  output ptoc_pkg::prep_t      prep_o
);

  logic [ptoc_pkg::CNT_W-1:0]    n;
  logic [ptoc_pkg::SUM_W-1:0]    s_sum;
  logic [ptoc_pkg::SUM_W-1:0]    scale;
  logic [ptoc_pkg::SUM_W-1:0]    s_eff;
  logic                          alpha_zero;
  logic signed [ptoc_pkg::DIFF_W-1:0]   row_diff;
  logic signed [2*ptoc_pkg::DIFF_W-1:0] index_prod;

  logic                          s1_valid_q;
  logic [ptoc_pkg::SUM_W-1:0]    s1_s_q;
  logic [ptoc_pkg::CNT_W-1:0]    s1_n_q;
  logic [ptoc_pkg::SUM_W-1:0]    s1_scale_q;
  logic                          s1_alpha_zero_q;
  logic [ptoc_pkg::COORD_W-1:0]  s1_col_q;
  logic [ptoc_pkg::INDEX_W-1:0]  s1_index_q;

  logic [ptoc_pkg::DIV3_W-1:0]   div3_prod;
  logic [ptoc_pkg::VALUE_W-1:0]  raw_value;
  ptoc_pkg::prep_t               prep_d;
  ptoc_pkg::prep_t               prep_q;
  logic                          s2_valid_q;

  always_comb begin
    if (cfg_i.mode == ptoc_pkg::MODE_TRINARY || !cfg_i.alpha) begin
      n = cfg_i.chans;
    end else begin
      n = cfg_i.chans - ptoc_pkg::CNT_W'(1);
    end
    if (n == '0) begin
      n = ptoc_pkg::CNT_W'(1);
    end

    s_sum = ptoc_pkg::SUM_W'(pix_i.chan_zero);
    if (n > ptoc_pkg::CNT_W'(1)) begin
      s_sum = s_sum + ptoc_pkg::SUM_W'(pix_i.chan_one);
    end
    if (n > ptoc_pkg::CNT_W'(2)) begin
      s_sum = s_sum + ptoc_pkg::SUM_W'(pix_i.chan_two);
    end
    if (n > ptoc_pkg::CNT_W'(3)) begin
      s_sum = s_sum + ptoc_pkg::SUM_W'(pix_i.chan_three);
    end

    // Full scale is 255 per averaged channel.
    scale = ptoc_pkg::SUM_W'({n, 8'h00} - {8'h00, n});
    s_eff = cfg_i.invert ? (scale - s_sum) : s_sum;

    case (cfg_i.chans)
      3'd2:    alpha_zero = (pix_i.chan_one == '0);
      3'd3:    alpha_zero = (pix_i.chan_two == '0);
      3'd4:    alpha_zero = (pix_i.chan_three == '0);
      default: alpha_zero = 1'b0;
    endcase

    // Rows count from the bottom of the map; the index wraps modulo its width.
    row_diff = $signed(ptoc_pkg::DIFF_W'({1'b0, cfg_i.height}) - ptoc_pkg::DIFF_W'(1)
                       - ptoc_pkg::DIFF_W'(pix_i.pixel_row));
    index_prod = (2*ptoc_pkg::DIFF_W)'($signed({1'b0, cfg_i.width}))
                 * (2*ptoc_pkg::DIFF_W)'(row_diff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_s_q          <= s_eff;
    s1_n_q          <= n;
    s1_scale_q      <= scale;
    s1_alpha_zero_q <= alpha_zero;
    s1_col_q        <= pix_i.pixel_column;
    s1_index_q      <= index_prod[ptoc_pkg::INDEX_W-1:0];
  end

  always_comb begin
    div3_prod = ptoc_pkg::DIV3_W'(s1_s_q) * ptoc_pkg::DIV3_MUL;
    case (s1_n_q)
      3'd2:    raw_value = s1_s_q[ptoc_pkg::VALUE_W:1];
      3'd3:    raw_value = div3_prod[ptoc_pkg::DIV3_SHIFT +: ptoc_pkg::VALUE_W];
      3'd4:    raw_value = s1_s_q[ptoc_pkg::VALUE_W+1:2];
      default: raw_value = s1_s_q[ptoc_pkg::VALUE_W-1:0];
    endcase

    prep_d.index_prod = s1_index_q;
    prep_d.col        = s1_col_q;
    prep_d.d          = ptoc_pkg::PROD_W'({s1_scale_q - s1_s_q, {ptoc_pkg::FRAC_W{1'b0}}});
    prep_d.occ_lim    = ptoc_pkg::PROD_W'(cfg_i.occ_thr) * ptoc_pkg::PROD_W'(s1_scale_q);
    prep_d.free_lim   = ptoc_pkg::PROD_W'(cfg_i.free_thr) * ptoc_pkg::PROD_W'(s1_scale_q);
    prep_d.raw_value  = raw_value;
    prep_d.alpha_zero = s1_alpha_zero_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prep_q <= prep_d;
  end

  assign valid_o = s2_valid_q;
  assign prep_o  = prep_q;

endmodule

`default_nettype wire

// File: sv/ptoc_classify.sv
`default_nettype none

module ptoc_classify (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire ptoc_pkg::prep_t prep_i,
  input  wire ptoc_pkg::cfg_t  cfg_i,
  output logic                 valid_o,
  output ptoc_pkg::div_in_t    div_o
);

  ptoc_pkg::side_t               side_d;
  logic [ptoc_pkg::PROD_W-1:0]   r_d;
  logic [ptoc_pkg::PROD_W-1:0]   den_d;

  logic                          s3_valid_q;
  ptoc_pkg::side_t               s3_side_q;
  logic [ptoc_pkg::PROD_W-1:0]   s3_r_q;
  logic [ptoc_pkg::PROD_W-1:0]   s3_den_q;

  logic                          s4_valid_q;
  ptoc_pkg::div_in_t             div_d;
  ptoc_pkg::div_in_t             div_q;

  always_comb begin
    side_d.index     = prep_i.index_prod + ptoc_pkg::INDEX_W'(prep_i.col);
    side_d.need_div  = 1'b0;
    side_d.value_fix = ptoc_pkg::VAL_SCALED_MIN;
    if (cfg_i.mode == ptoc_pkg::MODE_RAW) begin
      side_d.value_fix = prep_i.raw_value;
    end else if (prep_i.d > prep_i.occ_lim) begin
      side_d.value_fix = ptoc_pkg::VAL_OCCUPIED;
    end else if (prep_i.d < prep_i.free_lim) begin
      side_d.value_fix = ptoc_pkg::VAL_FREE;
    end else if (cfg_i.mode == ptoc_pkg::MODE_TRINARY || prep_i.alpha_zero) begin
      side_d.value_fix = ptoc_pkg::VAL_UNKNOWN;
    end else if (cfg_i.occ_thr > cfg_i.free_thr) begin
      side_d.need_div = 1'b1;
    end
    r_d   = prep_i.d - prep_i.free_lim;
    den_d = prep_i.occ_lim - prep_i.free_lim;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= valid_i;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_side_q <= side_d;
    s3_r_q    <= r_d;
    s3_den_q  <= den_d;
  end

  always_comb begin
    div_d.side = s3_side_q;
    div_d.num  = ptoc_pkg::NUM_W'(s3_r_q) * ptoc_pkg::NUM_MUL;
    div_d.den  = s3_den_q;
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
  end

  assign valid_o = s4_valid_q;
  assign div_o   = div_q;

endmodule

`default_nettype wire

// File: sv/ptoc_div.sv
`default_nettype none

module ptoc_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  input  wire ptoc_pkg::div_in_t div_i,
  output logic                   valid_o,
  output ptoc_pkg::div_out_t     res_o
);

  // For a cell that needs the division the quotient never exceeds 98, so one restoring step per quotient bit suffices.
  logic                               in_valid [ptoc_pkg::DIV_BITS];
  ptoc_pkg::side_t                    in_side  [ptoc_pkg::DIV_BITS];
  logic [ptoc_pkg::NUM_W-1:0]         in_rem   [ptoc_pkg::DIV_BITS];
  logic [ptoc_pkg::PROD_W-1:0]        in_den   [ptoc_pkg::DIV_BITS];
  logic [ptoc_pkg::DIV_BITS-1:0]      in_quo   [ptoc_pkg::DIV_BITS];

  logic                               valid_q  [ptoc_pkg::DIV_BITS];
  ptoc_pkg::side_t                    side_q   [ptoc_pkg::DIV_BITS];
  logic [ptoc_pkg::NUM_W-1:0]         rem_d    [ptoc_pkg::DIV_BITS];
  logic [ptoc_pkg::NUM_W-1:0]         rem_q    [ptoc_pkg::DIV_BITS];
  logic [ptoc_pkg::PROD_W-1:0]        den_q    [ptoc_pkg::DIV_BITS];
  logic [ptoc_pkg::DIV_BITS-1:0]      quo_d    [ptoc_pkg::DIV_BITS];
  logic [ptoc_pkg::DIV_BITS-1:0]      quo_q    [ptoc_pkg::DIV_BITS];

  for (genvar k = 0; k < ptoc_pkg::DIV_BITS; k++) begin : g_stage
    localparam int unsigned BIT = ptoc_pkg::DIV_BITS - 1 - k;
    logic [ptoc_pkg::NUM_W-1:0] shifted;
    logic                       fits;

    if (k == 0) begin : g_first
      assign in_valid[k] = valid_i;
      assign in_side[k]  = div_i.side;
      assign in_rem[k]   = div_i.num;
      assign in_den[k]   = div_i.den;
      assign in_quo[k]   = '0;
    end else begin : g_next
      assign in_valid[k] = valid_q[k-1];
      assign in_side[k]  = side_q[k-1];
      assign in_rem[k]   = rem_q[k-1];
      assign in_den[k]   = den_q[k-1];
      assign in_quo[k]   = quo_q[k-1];
    end

    always_comb begin
      shifted     = ptoc_pkg::NUM_W'(in_den[k]) << BIT;
      fits        = (in_rem[k] >= shifted);
      rem_d[k]    = fits ? (in_rem[k] - shifted) : in_rem[k];
      quo_d[k]    = in_quo[k];
      quo_d[k][BIT] = fits;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= in_valid[k];
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[k] <= in_side[k];
      rem_q[k]  <= rem_d[k];
      den_q[k]  <= in_den[k];
      quo_q[k]  <= quo_d[k];
    end
  end

  assign valid_o    = valid_q[ptoc_pkg::DIV_BITS-1];
  assign res_o.side = side_q[ptoc_pkg::DIV_BITS-1];
  assign res_o.quo  = quo_q[ptoc_pkg::DIV_BITS-1];

endmodule

`default_nettype wire

// File: sv/pixel_to_occupancy_cell.sv
// Channel  Dir  Handshake                   Payload
// pixel    in   start high, busy low        pixel_i   (ptoc_pkg::pix_t)
// cell     out  done_o high for one cycle   cell_o    (ptoc_pkg::cell_t)
// config   in   cfg_we_i high               cfg_idx_i, cfg_wdata_i
//
// One pixel word is taken in every cycle; busy is high only in the first cycle after reset.
// Between a pixel and its cell word lie five arithmetic stages
// (sum, products, compares, scaling, output) around a seven-stage quotient pipeline.
// Reset is asynchronous and clears the pipeline valid bits and the config registers.
// The receiver cannot stall, so done_o is a single-cycle strobe per word.
`default_nettype none

module pixel_to_occupancy_cell (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire ptoc_pkg::pix_t                   pixel_i,
  output logic                                  done_o,
  output ptoc_pkg::cell_t                       cell_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [ptoc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [ptoc_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  ptoc_pkg::cfg_t     cfg;
  logic               busy_q;
  logic               take;
  logic               prep_valid;
  ptoc_pkg::prep_t    prep;
  logic               cls_valid;
  ptoc_pkg::div_in_t  div_in;
  logic               div_valid;
  ptoc_pkg::div_out_t div_res;
  logic               done_q;
  ptoc_pkg::cell_t    cell_d;
  ptoc_pkg::cell_t    cell_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign take = start && !busy_q;

  ptoc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ptoc_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (take),
    .pix_i   (pixel_i),
    .cfg_i   (cfg),
    .valid_o (prep_valid),
    .prep_o  (prep)
  );

  ptoc_classify u_cls (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep_valid),
    .prep_i  (prep),
    .cfg_i   (cfg),
    .valid_o (cls_valid),
    .div_o   (div_in)
  );

  ptoc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cls_valid),
    .div_i   (div_in),
    .valid_o (div_valid),
    .res_o   (div_res)
  );

  always_comb begin
    cell_d.cell_index = div_res.side.index;
    if (div_res.side.need_div) begin
      cell_d.cell_value = ptoc_pkg::VAL_SCALED_MIN + ptoc_pkg::VALUE_W'(div_res.quo);
    end else begin
      cell_d.cell_value = div_res.side.value_fix;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign busy   = busy_q;
  assign done_o = done_q;
  assign cell_o = cell_q;

endmodule

`default_nettype wire

// File: sv/ptoc_checker.sv
`default_nettype none

module ptoc_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic done_o
);

  logic take;

  assign take = start && !busy;

  // Every accepted pixel yields exactly one cell word.
  a_take_gives_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> ##(ptoc_pkg::LATENCY) done_o)
    else $error("accepted pixel produced no cell word");

  a_done_has_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(take, ptoc_pkg::LATENCY))
    else $error("cell word without an accepted pixel");

  // The pipeline never refuses a pixel once out of reset.
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> !busy)
    else $error("busy raised during operation");

endmodule

bind pixel_to_occupancy_cell ptoc_checker u_ptoc_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o)
);

`default_nettype wire
